// File: design/bia_pkg.sv
// ----------------------------------------------------------------------------
// bia_pkg
// shared types and constants of the bitmap id allocator
// ----------------------------------------------------------------------------
`default_nettype none

package bia_pkg;

    // bits in each pool bitmap
    localparam int MAX_BITS  = 8192;
    localparam int MAP_WORDS = (MAX_BITS + 31) / 32;
    localparam int WORD_AW   = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
    localparam int MEM_AW    = WORD_AW + 1;
    localparam int MEM_DEPTH = 2 ** MEM_AW;
    localparam int IDX_W     = (MAX_BITS > 32) ? $clog2(MAX_BITS) : 5;
    localparam int CNT_W     = $clog2(MAX_BITS + 1);

    // field widths of requests, results and registers
    localparam int NUM_W  = 14;
    localparam int CFG_W  = 14;
    localparam int STAT_W = 2;
    localparam int ADDR_W = 4;
    localparam int DATA_W = 32;

    localparam logic [CFG_W-1:0] REG_RESET = 14'd8192;
    localparam logic [CNT_W-1:0] CNT_RESET =
        (32'(REG_RESET) > 32'(MAX_BITS)) ? CNT_W'(MAX_BITS) : CNT_W'(REG_RESET);

    localparam logic ACT_ALLOC  = 1'b0;
    localparam logic ACT_FREE   = 1'b1;
    localparam logic POOL_INODE = 1'b0;
    localparam logic POOL_BLOCK = 1'b1;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_SCAN,
        S_FREE_WR,
        S_DONE
    } state_t;

    typedef enum logic [1:0] {
        STAT_OK,
        STAT_FULL,
        STAT_RANGE
    } status_t;

    typedef enum logic [1:0] {
        REG_INODE_SIZE,
        REG_BLOCK_SIZE,
        REG_INODE_START,
        REG_BLOCK_START
    } reg_idx_t;

endpackage

`default_nettype wire

// File: design/bitmap_id_allocator_core.sv
// ----------------------------------------------------------------------------
// bitmap_id_allocator_core
// first-fit allocator over an inode pool and a data block pool
// ----------------------------------------------------------------------------
// Each request either allocates the lowest clear bit of the selected pool's
// bitmap (answering its one-based number and lowering the pool's free
// counter) or frees a given one-based number (clearing its bit and raising
// the counter). Both bitmaps live in one single-port-write, registered-read
// memory of 32-bit words, the pool bit forming the top address bit. After
// reset a clearing pass zeroes the memory, one word a cycle;
// s_tready stays low during it while register writes are taken as usual.
// An allocate scans the bitmap words in order, reading one word per cycle
// from the memory port, until it finds a clear bit or passes the pool's last word. A free
// reads the word and writes it back before the result; a rejected request or
// an allocate on a zero-sized pool goes straight to the result. One request
// is handled at a time. The result sits in an output register, so the next
// request is taken while the previous result still waits for m_tready.
// Writing a free-start register reloads that pool's free counter; register
// writes are expected only while the block is idle.
// ----------------------------------------------------------------------------
`default_nettype none

module bitmap_id_allocator_core
    import bia_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,

    // request stream
    input  wire logic              s_tvalid,
    output logic                   s_tready,
    input  wire logic [15:0]       s_tdata,   // [13:0] item_number, [15:14] zero
    input  wire logic [1:0]        s_tuser,   // [0] action, [1] pool

    // result stream
    output logic                   m_tvalid,
    input  wire logic              m_tready,
    output logic [31:0]            m_tdata,   // [13:0] number, [15:14] status,
                                              // [29:16] free_count, [31:30] zero

    // register port
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [ADDR_W-1:0] paddr,
    input  wire logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0]      prdata,
    output logic                   pready
);

    // bitmap memory
    logic [31:0]        mem [0:MEM_DEPTH-1];
    logic [31:0]        rd_data_reg;
    logic               mem_we;
    logic [MEM_AW-1:0]  mem_wa;
    logic [31:0]        mem_wd;
    logic               mem_re;
    logic [MEM_AW-1:0]  mem_ra;

    // control
    state_t             state_reg, state_next;
    logic [MEM_AW-1:0]  clr_addr_reg, clr_addr_next;
    logic [WORD_AW-1:0] word_reg, word_next;
    logic [WORD_AW-1:0] last_word_reg, last_word_next;
    logic [4:0]         tail_reg, tail_next;
    logic [4:0]         bit_reg, bit_next;
    logic               pool_reg, pool_next;

    // pending result
    logic [NUM_W-1:0]   res_number_reg, res_number_next;
    status_t            res_status_reg, res_status_next;

    // output register
    logic               m_tvalid_reg, m_tvalid_next;
    logic [NUM_W-1:0]   out_number_reg, out_number_next;
    status_t            out_status_reg, out_status_next;
    logic [NUM_W-1:0]   out_free_reg, out_free_next;

    // registers and counters
    logic [CFG_W-1:0]   inode_size_reg, inode_size_next;
    logic [CFG_W-1:0]   block_size_reg, block_size_next;
    logic [CFG_W-1:0]   inode_start_reg, inode_start_next;
    logic [CFG_W-1:0]   block_start_reg, block_start_next;
    logic [CNT_W-1:0]   inode_free_reg, inode_free_next;
    logic [CNT_W-1:0]   block_free_reg, block_free_next;

    // request decode
    logic               in_accept;
    logic               in_action;
    logic               in_pool;
    logic [NUM_W-1:0]   in_item;
    logic [CNT_W-1:0]   in_size_lim;
    logic [IDX_W-1:0]   in_item_m1;
    logic [IDX_W-1:0]   in_sz_m1;
    logic               in_alloc_empty;
    logic               in_free_bad;

    // scan datapath
    logic [31:0]        scan_mask;
    logic [31:0]        scan_zeros;
    logic               scan_hit;
    logic [4:0]         scan_bit;
    logic [CNT_W-1:0]   cnt_sel;
    logic               cfg_we;
    logic               out_load;

    function automatic logic [CNT_W-1:0] limit_bits(input logic [CFG_W-1:0] v);
        return (32'(v) > 32'(MAX_BITS)) ? CNT_W'(MAX_BITS) : CNT_W'(v);
    endfunction

    // lowest set bit of a word
    function automatic logic [4:0] first_set(input logic [31:0] z);
        logic [4:0] idx;
        idx = '0;
        for (int i = 31; i >= 0; i--) begin
            if (z[i])
            begin
                idx = 5'(i);
            end
        end
        return idx;
    endfunction

    assign pready   = 1'b1;
    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {2'b00, out_free_reg, out_status_reg, out_number_reg};

    assign in_accept   = s_tvalid && s_tready;
    assign in_action   = s_tuser[0];
    assign in_pool     = s_tuser[1];
    assign in_item     = s_tdata[NUM_W-1:0];
    assign in_size_lim = limit_bits((in_pool == POOL_BLOCK) ? block_size_reg : inode_size_reg);
    assign in_item_m1  = IDX_W'(32'(in_item) - 32'd1);
    assign in_sz_m1    = IDX_W'(32'(in_size_lim) - 32'd1);

    // allocate on a zero-sized pool answers full at once
    assign in_alloc_empty = (in_size_lim == '0);
    // free of number zero or beyond the pool
    assign in_free_bad    = (in_item == '0) || (32'(in_item) > 32'(in_size_lim));

    // only bits below the pool size count in the last word
    assign scan_mask  = (word_reg == last_word_reg) ? (32'hFFFF_FFFF >> (5'd31 - tail_reg))
                                                    : 32'hFFFF_FFFF;
    assign scan_zeros = ~rd_data_reg & scan_mask;
    assign scan_hit   = |scan_zeros;
    assign scan_bit   = first_set(scan_zeros);

    assign cnt_sel  = (pool_reg == POOL_BLOCK) ? block_free_reg : inode_free_reg;
    assign cfg_we   = psel && penable && pwrite && pready;
    assign out_load = (state_reg == S_DONE) && (!m_tvalid_reg || m_tready);

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_CLEAR:
            begin
                if (clr_addr_reg == MEM_AW'(MEM_DEPTH - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_accept)
                begin
                    if (in_action == ACT_ALLOC)
                    begin
                        state_next = in_alloc_empty ? S_DONE : S_SCAN;
                    end
                    else
                    begin
                        state_next = in_free_bad ? S_DONE : S_FREE_WR;
                    end
                end
            end
            S_SCAN:
            begin
                if (scan_hit || (word_reg == last_word_reg))
                begin
                    state_next = S_DONE;
                end
            end
            S_FREE_WR:
            begin
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (out_load)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // datapath, memory access and register updates
    always_comb
    begin
        mem_we           = 1'b0;
        mem_wa           = '0;
        mem_wd           = '0;
        mem_re           = 1'b0;
        mem_ra           = '0;
        clr_addr_next    = clr_addr_reg;
        word_next        = word_reg;
        last_word_next   = last_word_reg;
        tail_next        = tail_reg;
        bit_next         = bit_reg;
        pool_next        = pool_reg;
        res_number_next  = res_number_reg;
        res_status_next  = res_status_reg;
        m_tvalid_next    = m_tvalid_reg;
        out_number_next  = out_number_reg;
        out_status_next  = out_status_reg;
        out_free_next    = out_free_reg;
        inode_size_next  = inode_size_reg;
        block_size_next  = block_size_reg;
        inode_start_next = inode_start_reg;
        block_start_next = block_start_reg;
        inode_free_next  = inode_free_reg;
        block_free_next  = block_free_reg;

        case (state_reg)
            S_CLEAR:
            begin
                mem_we        = 1'b1;
                mem_wa        = clr_addr_reg;
                clr_addr_next = clr_addr_reg + 1'b1;
            end
            S_IDLE:
            begin
                if (in_accept)
                begin
                    pool_next       = in_pool;
                    last_word_next  = WORD_AW'(in_sz_m1 >> 5);
                    tail_next       = in_sz_m1[4:0];
                    bit_next        = in_item_m1[4:0];
                    res_number_next = '0;
                    res_status_next = STAT_OK;
                    if (in_action == ACT_ALLOC)
                    begin
                        word_next = '0;
                        if (in_alloc_empty)
                        begin
                            res_status_next = STAT_FULL;
                        end
                        else
                        begin
                            mem_re = 1'b1;
                            mem_ra = {in_pool, WORD_AW'(0)};
                        end
                    end
                    else
                    begin
                        word_next = WORD_AW'(in_item_m1 >> 5);
                        if (in_free_bad)
                        begin
                            res_status_next = STAT_RANGE;
                        end
                        else
                        begin
                            mem_re = 1'b1;
                            mem_ra = {in_pool, WORD_AW'(in_item_m1 >> 5)};
                        end
                    end
                end
            end
            S_SCAN:
            begin
                if (scan_hit)
                begin
                    // claim the bit and lower the counter
                    mem_we          = 1'b1;
                    mem_wa          = {pool_reg, word_reg};
                    mem_wd          = rd_data_reg | (32'd1 << scan_bit);
                    res_number_next = NUM_W'(32'({word_reg, scan_bit}) + 32'd1);
                    res_status_next = STAT_OK;
                    if (pool_reg == POOL_BLOCK)
                    begin
                        block_free_next = (cnt_sel != '0) ? cnt_sel - 1'b1 : cnt_sel;
                    end
                    else
                    begin
                        inode_free_next = (cnt_sel != '0) ? cnt_sel - 1'b1 : cnt_sel;
                    end
                end
                else if (word_reg == last_word_reg)
                begin
                    res_number_next = '0;
                    res_status_next = STAT_FULL;
                end
                else
                begin
                    mem_re    = 1'b1;
                    mem_ra    = {pool_reg, word_reg + 1'b1};
                    word_next = word_reg + 1'b1;
                end
            end
            S_FREE_WR:
            begin
                // clear the bit, counter saturates at MAX_BITS
                mem_we = 1'b1;
                mem_wa = {pool_reg, word_reg};
                mem_wd = rd_data_reg & ~(32'd1 << bit_reg);
                if (pool_reg == POOL_BLOCK)
                begin
                    block_free_next = (32'(cnt_sel) < 32'(MAX_BITS)) ? cnt_sel + 1'b1 : cnt_sel;
                end
                else
                begin
                    inode_free_next = (32'(cnt_sel) < 32'(MAX_BITS)) ? cnt_sel + 1'b1 : cnt_sel;
                end
            end
            S_DONE:
            begin
            end
            default:
            begin
            end
        endcase

        // output register
        if (out_load)
        begin
            m_tvalid_next   = 1'b1;
            out_number_next = res_number_reg;
            out_status_next = res_status_reg;
            out_free_next   = NUM_W'(cnt_sel);
        end
        else if (m_tready)
        begin
            m_tvalid_next = 1'b0;
        end

        // register writes, start registers reload their counter
        if (cfg_we)
        begin
            case (reg_idx_t'(paddr[3:2]))
                REG_INODE_SIZE:
                begin
                    inode_size_next = pwdata[CFG_W-1:0];
                end
                REG_BLOCK_SIZE:
                begin
                    block_size_next = pwdata[CFG_W-1:0];
                end
                REG_INODE_START:
                begin
                    inode_start_next = pwdata[CFG_W-1:0];
                    inode_free_next  = limit_bits(pwdata[CFG_W-1:0]);
                end
                REG_BLOCK_START:
                begin
                    block_start_next = pwdata[CFG_W-1:0];
                    block_free_next  = limit_bits(pwdata[CFG_W-1:0]);
                end
                default:
                begin
                end
            endcase
        end
    end

    // register read
    always_comb
    begin
        case (reg_idx_t'(paddr[3:2]))
            REG_INODE_SIZE:  prdata = DATA_W'(inode_size_reg);
            REG_BLOCK_SIZE:  prdata = DATA_W'(block_size_reg);
            REG_INODE_START: prdata = DATA_W'(inode_start_reg);
            REG_BLOCK_START: prdata = DATA_W'(block_start_reg);
            default:         prdata = '0;
        endcase
    end

    // bitmap memory, registered read
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_wa] <= mem_wd;
        end
        if (mem_re)
        begin
            rd_data_reg <= mem[mem_ra];
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        word_reg       <= word_next;
        last_word_reg  <= last_word_next;
        tail_reg       <= tail_next;
        bit_reg        <= bit_next;
        pool_reg       <= pool_next;
        res_number_reg <= res_number_next;
        res_status_reg <= res_status_next;
        out_number_reg <= out_number_next;
        out_status_reg <= out_status_next;
        out_free_reg   <= out_free_next;
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_CLEAR;
            clr_addr_reg    <= '0;
            m_tvalid_reg    <= 1'b0;
            inode_size_reg  <= REG_RESET;
            block_size_reg  <= REG_RESET;
            inode_start_reg <= REG_RESET;
            block_start_reg <= REG_RESET;
            inode_free_reg  <= CNT_RESET;
            block_free_reg  <= CNT_RESET;
        end
        else
        begin
            state_reg       <= state_next;
            clr_addr_reg    <= clr_addr_next;
            m_tvalid_reg    <= m_tvalid_next;
            inode_size_reg  <= inode_size_next;
            block_size_reg  <= block_size_next;
            inode_start_reg <= inode_start_next;
            block_start_reg <= block_start_next;
            inode_free_reg  <= inode_free_next;
            block_free_reg  <= block_free_next;
        end
    end

endmodule

`default_nettype wire
